[hdl/hlfr_pkg.sv]
// Shared types and constants of the header/length frame receiver.
// Used by the parser, the output stage and the top level; no dependencies.
`default_nettype none

package hlfr_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;

	typedef enum logic [1:0] {
		KIND_CMD  = 2'd0,
		KIND_LEN  = 2'd1,
		KIND_DATA = 2'd2,
		KIND_END  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] value;
		logic [BYTE_W-1:0] data_index;
		logic              frame_ok;
		logic              last;
	} result_t;

endpackage

`default_nettype wire

[hdl/header_length_frame_receiver.sv]
// Header/length frame receiver top level: configuration register, parser and
// output register. Depends on hlfr_pkg, hlfr_parser and hlfr_out_stage.
//
// Takes one received byte per transfer on the slave side and deframes frames of
// HEADER_LEN header bytes (each equal to the header register), a command byte, a
// length byte L, L data bytes and a check byte. Header bytes give no output; a
// wrong header byte is dropped and the parser waits for a new header. Command,
// length and data bytes are forwarded with their kind in m_tuser and, for data,
// their payload index. The check byte gives a frame-end transfer with m_tlast
// high and frame_ok set when it equals the 8-bit sum of all earlier frame bytes,
// header included. Each byte passes through the input register and the output
// register, and one byte is taken every cycle while the master side keeps
// m_tready high. The header register resets to 0xAA and should only be written
// while no frame is in flight.
`default_nettype none

module header_length_frame_receiver #(
	parameter int unsigned HEADER_LEN = 2
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [7:0]  cfg_data,   // header_byte
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,    // rx_byte
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,    // value [7:0], data_index [15:8], frame_ok [16], zero fill
	output logic [1:0]  m_tuser,    // kind
	output logic        m_tlast     // frame end
);
	import hlfr_pkg::*;

	logic [BYTE_W-1:0] header_q;
	logic              res_valid;
	logic              res_ready;
	result_t           res;
	result_t           out_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
		end else if (cfg_valid) begin
			header_q <= cfg_data;
		end
	end

	hlfr_parser #(
		.HEADER_LEN(HEADER_LEN)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata),
		.header_byte(header_q),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	hlfr_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (res_valid),
		.in_ready (res_ready),
		.in_res   (res),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (out_res)
	);

	assign m_tdata = {7'd0, out_res.frame_ok, out_res.data_index, out_res.value};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last;

endmodule

`default_nettype wire

[hdl/hlfr_parser.sv]
// Frame parser: input byte register, frame position/length/sum state and the
// decode of one byte into at most one result. Depends on hlfr_pkg.
`default_nettype none

module hlfr_parser #(
	parameter int unsigned HEADER_LEN = 2
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire  [hlfr_pkg::BYTE_W-1:0] in_byte,
	input  wire  [hlfr_pkg::BYTE_W-1:0] header_byte,
	output logic                      res_valid,
	input  wire                       res_ready,
	output hlfr_pkg::result_t         res
);
	import hlfr_pkg::*;

	// Highest position is the check byte after a full 255-byte payload.
	localparam int unsigned POS_W = $clog2(HEADER_LEN + 258);
	localparam logic [POS_W-1:0] CMD_POS  = POS_W'(HEADER_LEN);
	localparam logic [POS_W-1:0] LEN_POS  = POS_W'(HEADER_LEN + 1);
	localparam logic [POS_W-1:0] DATA_POS = POS_W'(HEADER_LEN + 2);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [BYTE_W-1:0] len_q, len_d;
	logic [BYTE_W-1:0] sum_q, sum_d;
	logic [POS_W-1:0]  data_end;
	logic [POS_W-1:0]  data_off;
	logic              has_res;
	logic              fire;

	assign data_end = DATA_POS + POS_W'(len_q);
	assign data_off = pos_q - DATA_POS;

	always_comb begin
		pos_d          = pos_q + POS_W'(1);
		len_d          = len_q;
		sum_d          = sum_q + byte_s1;
		has_res        = 1'b1;
		res.kind       = KIND_DATA;
		res.value      = byte_s1;
		res.data_index = '0;
		res.frame_ok   = 1'b0;
		res.last       = 1'b0;
		if (pos_q < CMD_POS) begin
			has_res = 1'b0;
			// A mismatching header byte is dropped and the frame starts over.
			if (byte_s1 != header_byte) begin
				pos_d = '0;
				len_d = '0;
				sum_d = '0;
			end else if (pos_q == '0) begin
				sum_d = byte_s1;
			end
		end else if (pos_q == CMD_POS) begin
			res.kind = KIND_CMD;
		end else if (pos_q == LEN_POS) begin
			res.kind = KIND_LEN;
			len_d    = byte_s1;
		end else if (pos_q < data_end) begin
			res.kind       = KIND_DATA;
			res.data_index = data_off[BYTE_W-1:0];
		end else begin
			res.kind     = KIND_END;
			res.frame_ok = (byte_s1 == sum_q);
			res.last     = 1'b1;
			pos_d        = '0;
			len_d        = '0;
			sum_d        = '0;
		end
	end

	assign fire      = valid_s1 && (res_ready || !has_res);
	assign in_ready  = !valid_s1 || res_ready || !has_res;
	assign res_valid = valid_s1 && has_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_q    <= '0;
			len_q    <= '0;
			sum_q    <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (fire) begin
				pos_q <= pos_d;
				len_q <= len_d;
				sum_q <= sum_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q > LEN_POS) |-> (pos_q <= data_end))
		else $error("frame position ran past the check byte");

	a_sum_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q == '0) |-> (sum_q == '0 && len_q == '0))
		else $error("frame state not cleared at frame start");

	a_end_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res.last) |=> (pos_q == '0))
		else $error("parser did not return to frame start after check byte");

	a_hdr_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && pos_q < CMD_POS) |-> !res_valid)
		else $error("header byte produced a result");

endmodule

`default_nettype wire

[hdl/hlfr_out_stage.sv]
// Output register of the frame receiver: holds one result until the master
// side takes it, and loads a new one in the same cycle. Depends on hlfr_pkg.
`default_nettype none

module hlfr_out_stage (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  hlfr_pkg::result_t  in_res,
	output logic               out_valid,
	input  wire                out_ready,
	output hlfr_pkg::result_t  out_res
);
	import hlfr_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_q <= in_res;
		end
	end

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (res_q.last == (res_q.kind == KIND_END)))
		else $error("last flag disagrees with result kind");

	a_ok_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && res_q.frame_ok) |-> res_q.last)
		else $error("frame_ok set on a result that is not a frame end");

	a_index_data: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && res_q.kind != KIND_DATA) |-> (res_q.data_index == '0))
		else $error("data index set on a result that is not a data byte");

endmodule

`default_nettype wire
